// ===== sv/lbm_pkg.sv =====
package lbm_pkg;

    localparam int DIST_W  = 32;
    localparam int RHO_W   = DIST_W + 3;
    localparam int VJ_W    = DIST_W + 1;
    localparam int COEF_W  = 19;
    localparam int PROD_W  = COEF_W + RHO_W;
    localparam int FEQ_W   = 38;
    localparam int RES_W   = 42;
    localparam int ADDR_W  = 5;
    localparam int NUM_DIR = 5;

    // register map, word index = paddr[4:2]
    localparam logic [2:0] REG_WAVE_SPEED_SQ   = 3'd0;
    localparam logic [2:0] REG_INV_TAU         = 3'd1;
    localparam logic [2:0] REG_MIRROR_X_LOW    = 3'd2;
    localparam logic [2:0] REG_MIRROR_X_HIGH   = 3'd3;
    localparam logic [2:0] REG_MIRROR_CENTER_Y = 3'd4;
    localparam logic [2:0] REG_MIRROR_RADIUS   = 3'd5;

    localparam logic [15:0] WAVE_SPEED_SQ_RST   = 16'd16384;
    localparam logic [17:0] INV_TAU_RST         = 18'd131072;
    localparam logic [9:0]  MIRROR_X_LOW_RST    = 10'd50;
    localparam logic [9:0]  MIRROR_X_HIGH_RST   = 10'd200;
    localparam logic [7:0]  MIRROR_CENTER_Y_RST = 8'd100;
    localparam logic [9:0]  MIRROR_RADIUS_RST   = 10'd100;

    // direction slots
    localparam int SLOT_REST  = 0;
    localparam int SLOT_EAST  = 1;
    localparam int SLOT_NORTH = 2;
    localparam int SLOT_WEST  = 3;
    localparam int SLOT_SOUTH = 4;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } lbm_ld_t;

    typedef struct packed {
        logic src;
        logic mirror;
    } lbm_cls_t;

    function automatic logic signed [DIST_W-1:0] sat32(input logic signed [RES_W-1:0] v);
        logic signed [RES_W-1:0] hi;
        logic signed [RES_W-1:0] lo;
        logic signed [DIST_W-1:0] r;
        hi = RES_W'(32'sh7fffffff);
        lo = RES_W'(32'sh80000000);
        if (v > hi)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < lo)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[DIST_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/lbm_if.sv =====
interface lbm_cell_if;
    logic                valid;
    logic                ready;
    logic [9:0]          cell_x;
    logic [7:0]          cell_y;
    logic signed [31:0]  dist_rest;
    logic signed [31:0]  dist_east;
    logic signed [31:0]  dist_north;
    logic signed [31:0]  dist_west;
    logic signed [31:0]  dist_south;
    logic signed [31:0]  source_density;

    modport source (
        output valid, cell_x, cell_y, dist_rest, dist_east, dist_north, dist_west,
               dist_south, source_density,
        input  ready
    );
    modport sink (
        input  valid, cell_x, cell_y, dist_rest, dist_east, dist_north, dist_west,
               dist_south, source_density,
        output ready
    );
endinterface

interface lbm_result_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  new_rest;
    logic signed [31:0]  new_east;
    logic signed [31:0]  new_north;
    logic signed [31:0]  new_west;
    logic signed [31:0]  new_south;

    modport source (
        output valid, new_rest, new_east, new_north, new_west, new_south,
        input  ready
    );
    modport sink (
        input  valid, new_rest, new_east, new_north, new_west, new_south,
        output ready
    );
endinterface

// ===== sv/lbm_mirror.sv =====
module lbm_mirror (
    input  logic              clk,
    input  lbm_pkg::lbm_ld_t  ctl,
    input  logic              src,
    input  logic              in_range,
    input  logic signed [10:0] dx,
    input  logic signed [8:0] dy,
    input  logic [9:0]        radius,
    output lbm_pkg::lbm_cls_t cls
);

    logic signed [21:0] dx_sq;
    logic signed [17:0] dy_sq;
    logic [19:0]        dx2_reg;
    logic [15:0]        dy2_reg;
    logic [19:0]        rr2_reg;
    logic               src2_reg;
    logic               range2_reg;
    logic [20:0]        dist_sum;
    lbm_pkg::lbm_cls_t  cls3_next;
    lbm_pkg::lbm_cls_t  cls3_reg;
    lbm_pkg::lbm_cls_t  cls4_reg;
    lbm_pkg::lbm_cls_t  cls5_reg;

    assign dx_sq = 22'(dx) * 22'(dx);
    assign dy_sq = 18'(dy) * 18'(dy);

    always_ff @(posedge clk)
    begin
        if (ctl.s2)
        begin
            dx2_reg    <= dx_sq[19:0];
            dy2_reg    <= dy_sq[15:0];
            rr2_reg    <= 20'(radius) * 20'(radius);
            src2_reg   <= src;
            range2_reg <= in_range;
        end
    end

    // source column always wins over the reflector
    always_comb
    begin
        dist_sum         = {1'b0, dx2_reg} + {5'b0, dy2_reg};
        cls3_next.src    = src2_reg;
        cls3_next.mirror = range2_reg && !src2_reg && (dist_sum >= {1'b0, rr2_reg});
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s3)
        begin
            cls3_reg <= cls3_next;
        end
        if (ctl.s4)
        begin
            cls4_reg <= cls3_reg;
        end
        if (ctl.s5)
        begin
            cls5_reg <= cls4_reg;
        end
    end

    assign cls = cls5_reg;

endmodule

// ===== sv/lbm_lane.sv =====
module lbm_lane (
    input  logic                                   clk,
    input  lbm_pkg::lbm_ld_t                       ctl,
    input  logic signed [lbm_pkg::COEF_W-1:0]      coef,
    input  logic signed [lbm_pkg::RHO_W-1:0]       rho,
    input  logic signed [lbm_pkg::VJ_W-1:0]        vj,
    input  logic signed [lbm_pkg::DIST_W-1:0]      f,
    input  logic [17:0]                            inv_tau,
    output logic signed [lbm_pkg::DIST_W-1:0]      relaxed,
    output logic signed [lbm_pkg::DIST_W-1:0]      equil
);

    localparam int SUM_W  = lbm_pkg::PROD_W + 1;
    localparam int P1_W   = 19 + lbm_pkg::DIST_W;
    localparam int P2_W   = 19 + lbm_pkg::FEQ_W;
    localparam int RSUM_W = P2_W + 1;

    logic signed [lbm_pkg::PROD_W-1:0] prod_next;
    logic signed [lbm_pkg::PROD_W-1:0] prod_reg;
    logic signed [lbm_pkg::VJ_W-1:0]   vj_reg;
    logic signed [lbm_pkg::DIST_W-1:0] f2_reg;
    logic signed [SUM_W-1:0]           feq_sum;
    logic signed [lbm_pkg::FEQ_W-1:0]  feq3_reg;
    logic signed [lbm_pkg::DIST_W-1:0] f3_reg;
    logic signed [18:0]                tau_s;
    logic signed [18:0]                omr;
    logic signed [P1_W-1:0]            p1_next;
    logic signed [P2_W-1:0]            p2_next;
    logic signed [P1_W-1:0]            p1_reg;
    logic signed [P2_W-1:0]            p2_reg;
    logic signed [lbm_pkg::FEQ_W-1:0]  feq4_reg;
    logic signed [RSUM_W-1:0]          rsum;
    logic signed [lbm_pkg::DIST_W-1:0] relaxed_reg;
    logic signed [lbm_pkg::DIST_W-1:0] equil_reg;

    // feq = (coef*rho + vj*2^16 + 2^16) >> 17, rest lane uses a doubled coefficient
    assign prod_next = lbm_pkg::PROD_W'(coef) * lbm_pkg::PROD_W'(rho);
    assign feq_sum   = SUM_W'(prod_reg) + (SUM_W'(vj_reg) <<< 16) + SUM_W'(65536);

    assign tau_s   = $signed({1'b0, inv_tau});
    assign omr     = 19'sd65536 - tau_s;
    assign p1_next = P1_W'(omr) * P1_W'(f3_reg);
    assign p2_next = P2_W'(tau_s) * P2_W'(feq3_reg);
    assign rsum    = RSUM_W'(p1_reg) + RSUM_W'(p2_reg) + RSUM_W'(32768);

    always_ff @(posedge clk)
    begin
        if (ctl.s2)
        begin
            prod_reg <= prod_next;
            vj_reg   <= vj;
            f2_reg   <= f;
        end
        if (ctl.s3)
        begin
            feq3_reg <= feq_sum[SUM_W-1:17];
            f3_reg   <= f2_reg;
        end
        if (ctl.s4)
        begin
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            feq4_reg <= feq3_reg;
        end
        if (ctl.s5)
        begin
            relaxed_reg <= lbm_pkg::sat32(rsum[RSUM_W-1:16]);
            equil_reg   <= lbm_pkg::sat32(lbm_pkg::RES_W'(feq4_reg));
        end
    end

    assign relaxed = relaxed_reg;
    assign equil   = equil_reg;

endmodule

// ===== sv/lbm_d2q5_mirror_cell_collision_core.sv =====
// channel    dir   handshake      word
// cells      in    valid/ready    cell_x, cell_y, dist_rest..dist_south, source_density
// results    out   valid/ready    new_rest, new_east, new_north, new_west, new_south
// apb        in    psel/penable   paddr, pwdata, prdata (pready tied high)
//
// one word per cycle sustained while results.ready stays high; results.valid rises once an
// accepted word has passed the five pipeline stages and the output register
// rst_n clears the valid bits and loads the register defaults asynchronously
// a stalled results channel fills the pipeline bubbles first, then drops cells.ready
module lbm_d2q5_mirror_cell_collision_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lbm_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    lbm_cell_if.sink                          cells,
    lbm_result_if.source                      results
);

    localparam int NDIR = lbm_pkg::NUM_DIR;

    logic [15:0] wave_speed_sq_reg;
    logic [17:0] inv_tau_reg;
    logic [9:0]  mirror_x_low_reg;
    logic [9:0]  mirror_x_high_reg;
    logic [7:0]  mirror_center_y_reg;
    logic [9:0]  mirror_radius_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    logic [5:1]  v_reg;
    logic [5:1]  v_next;
    logic [5:1]  ld;
    logic        vo_reg;
    logic        vo_next;
    logic        ld_o;
    lbm_pkg::lbm_ld_t ctl;

    logic signed [lbm_pkg::RHO_W-1:0]  rho_next;
    logic signed [lbm_pkg::RHO_W-1:0]  rho_reg;
    logic signed [lbm_pkg::VJ_W-1:0]   jx_reg;
    logic signed [lbm_pkg::VJ_W-1:0]   jy_reg;
    logic signed [lbm_pkg::DIST_W-1:0] f_reg [NDIR];
    logic        src_reg;
    logic        in_range_reg;
    logic signed [10:0] dx_reg;
    logic signed [8:0]  dy_reg;

    logic signed [19:0]                 coef_wide;
    logic signed [lbm_pkg::COEF_W-1:0]  coef_rest;
    logic signed [lbm_pkg::COEF_W-1:0]  coef_move;
    logic signed [lbm_pkg::COEF_W-1:0]  lane_coef [NDIR];
    logic signed [lbm_pkg::VJ_W-1:0]    lane_vj [NDIR];
    logic signed [lbm_pkg::DIST_W-1:0]  rel [NDIR];
    logic signed [lbm_pkg::DIST_W-1:0]  eqv [NDIR];
    logic signed [lbm_pkg::DIST_W-1:0]  out_next [NDIR];
    logic signed [lbm_pkg::DIST_W-1:0]  out_reg [NDIR];
    lbm_pkg::lbm_cls_t                  cls5;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_speed_sq_reg   <= lbm_pkg::WAVE_SPEED_SQ_RST;
            inv_tau_reg         <= lbm_pkg::INV_TAU_RST;
            mirror_x_low_reg    <= lbm_pkg::MIRROR_X_LOW_RST;
            mirror_x_high_reg   <= lbm_pkg::MIRROR_X_HIGH_RST;
            mirror_center_y_reg <= lbm_pkg::MIRROR_CENTER_Y_RST;
            mirror_radius_reg   <= lbm_pkg::MIRROR_RADIUS_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                lbm_pkg::REG_WAVE_SPEED_SQ:   wave_speed_sq_reg   <= pwdata[15:0];
                lbm_pkg::REG_INV_TAU:         inv_tau_reg         <= pwdata[17:0];
                lbm_pkg::REG_MIRROR_X_LOW:    mirror_x_low_reg    <= pwdata[9:0];
                lbm_pkg::REG_MIRROR_X_HIGH:   mirror_x_high_reg   <= pwdata[9:0];
                lbm_pkg::REG_MIRROR_CENTER_Y: mirror_center_y_reg <= pwdata[7:0];
                lbm_pkg::REG_MIRROR_RADIUS:   mirror_radius_reg   <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            lbm_pkg::REG_WAVE_SPEED_SQ:   prdata = {16'b0, wave_speed_sq_reg};
            lbm_pkg::REG_INV_TAU:         prdata = {14'b0, inv_tau_reg};
            lbm_pkg::REG_MIRROR_X_LOW:    prdata = {22'b0, mirror_x_low_reg};
            lbm_pkg::REG_MIRROR_X_HIGH:   prdata = {22'b0, mirror_x_high_reg};
            lbm_pkg::REG_MIRROR_CENTER_Y: prdata = {24'b0, mirror_center_y_reg};
            lbm_pkg::REG_MIRROR_RADIUS:   prdata = {22'b0, mirror_radius_reg};
            default:                      prdata = 32'b0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    // a stage loads when it is empty or the stage after it loads
    always_comb
    begin
        ld_o  = !vo_reg || results.ready;
        ld[5] = !v_reg[5] || ld_o;
        for (int k = 4; k >= 1; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
        v_next[1] = ld[1] ? cells.valid : v_reg[1];
        for (int k = 2; k <= 5; k++)
        begin
            v_next[k] = ld[k] ? v_reg[k-1] : v_reg[k];
        end
        vo_next = ld_o ? v_reg[5] : vo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v_reg  <= v_next;
            vo_reg <= vo_next;
        end
    end

    assign cells.ready = ld[1];
    assign ctl.s2      = ld[2];
    assign ctl.s3      = ld[3];
    assign ctl.s4      = ld[4];
    assign ctl.s5      = ld[5];

    // ---------------- moments ----------------
    always_comb
    begin
        if (cells.cell_x == 10'd0)
        begin
            rho_next = lbm_pkg::RHO_W'(cells.source_density);
        end
        else
        begin
            rho_next = lbm_pkg::RHO_W'(cells.dist_rest) + lbm_pkg::RHO_W'(cells.dist_east)
                     + lbm_pkg::RHO_W'(cells.dist_north) + lbm_pkg::RHO_W'(cells.dist_west)
                     + lbm_pkg::RHO_W'(cells.dist_south);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            rho_reg       <= rho_next;
            jx_reg        <= lbm_pkg::VJ_W'(cells.dist_east) - lbm_pkg::VJ_W'(cells.dist_west);
            jy_reg        <= lbm_pkg::VJ_W'(cells.dist_north) - lbm_pkg::VJ_W'(cells.dist_south);
            f_reg[lbm_pkg::SLOT_REST]  <= cells.dist_rest;
            f_reg[lbm_pkg::SLOT_EAST]  <= cells.dist_east;
            f_reg[lbm_pkg::SLOT_NORTH] <= cells.dist_north;
            f_reg[lbm_pkg::SLOT_WEST]  <= cells.dist_west;
            f_reg[lbm_pkg::SLOT_SOUTH] <= cells.dist_south;
            src_reg       <= (cells.cell_x == 10'd0);
            in_range_reg  <= (cells.cell_x >= mirror_x_low_reg)
                          && (cells.cell_x <= mirror_x_high_reg);
            dx_reg        <= $signed({1'b0, cells.cell_x}) - $signed({1'b0, mirror_x_low_reg});
            dy_reg        <= $signed({1'b0, cells.cell_y}) - $signed({1'b0, mirror_center_y_reg});
        end
    end

    // rest lane runs at 2*(1 - 2*c2) so that every lane rounds at 2^17
    assign coef_wide = 20'sd131072 - $signed({2'b00, wave_speed_sq_reg, 2'b00});
    assign coef_rest = coef_wide[lbm_pkg::COEF_W-1:0];
    assign coef_move = $signed({3'b000, wave_speed_sq_reg});

    always_comb
    begin
        lane_coef[lbm_pkg::SLOT_REST]  = coef_rest;
        lane_coef[lbm_pkg::SLOT_EAST]  = coef_move;
        lane_coef[lbm_pkg::SLOT_NORTH] = coef_move;
        lane_coef[lbm_pkg::SLOT_WEST]  = coef_move;
        lane_coef[lbm_pkg::SLOT_SOUTH] = coef_move;
        lane_vj[lbm_pkg::SLOT_REST]    = '0;
        lane_vj[lbm_pkg::SLOT_EAST]    = jx_reg;
        lane_vj[lbm_pkg::SLOT_NORTH]   = jy_reg;
        lane_vj[lbm_pkg::SLOT_WEST]    = -jx_reg;
        lane_vj[lbm_pkg::SLOT_SOUTH]   = -jy_reg;
    end

    // ---------------- lanes ----------------
    for (genvar g = 0; g < NDIR; g++)
    begin : g_lane
        lbm_lane u_lane (
            .clk     (clk),
            .ctl     (ctl),
            .coef    (lane_coef[g]),
            .rho     (rho_reg),
            .vj      (lane_vj[g]),
            .f       (f_reg[g]),
            .inv_tau (inv_tau_reg),
            .relaxed (rel[g]),
            .equil   (eqv[g])
        );
    end

    lbm_mirror u_mirror (
        .clk      (clk),
        .ctl      (ctl),
        .src      (src_reg),
        .in_range (in_range_reg),
        .dx       (dx_reg),
        .dy       (dy_reg),
        .radius   (mirror_radius_reg),
        .cls      (cls5)
    );

    // ---------------- merge ----------------
    always_comb
    begin
        if (cls5.src)
        begin
            for (int s = 0; s < NDIR; s++)
            begin
                out_next[s] = eqv[s];
            end
        end
        else if (cls5.mirror)
        begin
            // bounce-back: each moving direction lands in its opposite slot
            out_next[lbm_pkg::SLOT_REST]  = rel[lbm_pkg::SLOT_REST];
            out_next[lbm_pkg::SLOT_EAST]  = rel[lbm_pkg::SLOT_WEST];
            out_next[lbm_pkg::SLOT_NORTH] = rel[lbm_pkg::SLOT_SOUTH];
            out_next[lbm_pkg::SLOT_WEST]  = rel[lbm_pkg::SLOT_EAST];
            out_next[lbm_pkg::SLOT_SOUTH] = rel[lbm_pkg::SLOT_NORTH];
        end
        else
        begin
            for (int s = 0; s < NDIR; s++)
            begin
                out_next[s] = rel[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_o)
        begin
            for (int s = 0; s < NDIR; s++)
            begin
                out_reg[s] <= out_next[s];
            end
        end
    end

    assign results.valid     = vo_reg;
    assign results.new_rest  = out_reg[lbm_pkg::SLOT_REST];
    assign results.new_east  = out_reg[lbm_pkg::SLOT_EAST];
    assign results.new_north = out_reg[lbm_pkg::SLOT_NORTH];
    assign results.new_west  = out_reg[lbm_pkg::SLOT_WEST];
    assign results.new_south = out_reg[lbm_pkg::SLOT_SOUTH];

    // ---------------- assertions ----------------
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (cells.valid && cells.ready) |=> v_reg[1])
        else $error("accepted word did not enter the first stage");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && vo_reg && !results.ready) |-> !cells.ready)
        else $error("input taken while the pipeline is full and stalled");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[5] && ld_o) |=> vo_reg)
        else $error("word lost between last stage and output register");

endmodule
